### src/clock_tempo_meter_core_defines.svh
// assertion helpers shared by the tempo meter rtl
`ifndef CLOCK_TEMPO_METER_CORE_DEFINES_SVH
`define CLOCK_TEMPO_METER_CORE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define CTM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication violated");

// condition that must hold on every rising clock edge outside reset
`define CTM_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: invariant violated");

`endif

### src/ctm_pkg.sv
`timescale 1ns / 1ps

package ctm_pkg;

   // fixed field widths
   localparam int MV_W       = 15;
   localparam int RATE_W     = 18;
   localparam int OUT_W      = 24;
   localparam int FILL_OUT_W = 8;
   localparam int CSR_IDX_W  = 2;

   // tenths of bpm per sample-rate unit: 60 s * 10
   localparam int SCALE_W = 10;
   localparam logic [SCALE_W-1:0] TEMPO_SCALE = 10'd600;

   localparam logic [OUT_W-1:0]      OUT_MAX      = 24'hFFFFFF;
   localparam logic [FILL_OUT_W-1:0] FILL_OUT_MAX = 8'hFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_THRESH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_THRESH = 2'd2;

   // register reset values
   localparam logic [RATE_W-1:0]      RATE_RESET = 18'd44100;
   localparam logic signed [MV_W-1:0] RISE_RESET = 15'sd1000;
   localparam logic signed [MV_W-1:0] FALL_RESET = 15'sd0;

   // window bookkeeping commands
   typedef struct packed {
      logic push;
      logic sub;
      logic clear;
   } window_ctrl_type;

endpackage

### src/clock_tempo_meter_core.sv
// Tempo meter for an external clock signal.
// Request channel (req_valid / req_stall): one voltage sample per transfer
// with a connected flag. A Schmitt trigger on the sample finds rising edges
// and a counter measures samples between them. Each edge after the first
// one of a connection yields one result on the response channel
// (rsp_valid / rsp_stall): averaged tempo in tenths of bpm, the period just
// ended and the number of periods averaged. Samples without an edge give no
// result and are taken back to back, one per cycle.
// An edge sample passes through the multiply states and then the
// bit-serial divider that forms 600 * rate * n / total, one quotient
// bit per cycle; req_stall stays high from then until the sequencer is idle.
// The result sits in an output register, so a new sample is accepted while
// it waits; a stalled result only holds off the next edge's final step.
// Registers (csr_we / csr_index / csr_wdata) are to be written only while idle; the block does not enforce it.
// Synchronous reset restores register defaults and clears the trigger,
// counter and averaging window; no memory sweep is needed.
`timescale 1ns / 1ps
`include "clock_tempo_meter_core_defines.svh"

module clock_tempo_meter_core import ctm_pkg::*; #(
   parameter int WINDOW_DEPTH = 128,
   parameter int COUNT_BITS   = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [MV_W-1:0] req_sample_mv,
   input  logic                  req_connected,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [OUT_W-1:0]      rsp_tempo_tenths,
   output logic [OUT_W-1:0]      rsp_period_samples,
   output logic [FILL_OUT_W-1:0] rsp_window_fill,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [RATE_W-1:0]     csr_wdata
);

   localparam int TOTAL_W  = COUNT_BITS + $clog2(WINDOW_DEPTH) + 1;
   localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
   localparam int R600_W   = RATE_W + SCALE_W;
   localparam int NUM_W    = R600_W + FILL_W;
   localparam int PER_CW   = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;
   localparam int FILL_CW  = (FILL_W > FILL_OUT_W) ? FILL_W : FILL_OUT_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL    = 3'd1;
   localparam logic [2:0] ST_MUL2   = 3'd2;
   localparam logic [2:0] ST_DSTART = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_FIN    = 3'd5;

   // configuration registers
   logic [RATE_W-1:0]       rate_ff;
   logic signed [MV_W-1:0]  rise_ff;
   logic signed [MV_W-1:0]  fall_ff;

   // control state
   logic [2:0]              state_ff, state_in;
   logic                    trig_ff, trig_in;
   logic                    was_ff, was_in;
   logic                    await_ff, await_in;
   logic [COUNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [OUT_W-1:0]        last_ff, last_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [COUNT_BITS-1:0]   period_ff, period_in;
   logic [R600_W-1:0]       r600_ff;
   logic [FILL_W-1:0]       n_ff;
   logic [TOTAL_W-1:0]      den_ff;
   logic [NUM_W-1:0]        num_ff;
   logic [OUT_W-1:0]        tempo_out_ff;
   logic [OUT_W-1:0]        period_out_ff;
   logic [FILL_OUT_W-1:0]   fill_out_ff;

   logic                    req_xfer;
   logic                    edge_det;
   logic                    await_eff;
   logic [COUNT_BITS-1:0]   cnt_inc;
   window_ctrl_type         win_ctrl;
   logic [TOTAL_W-1:0]      win_total;
   logic [FILL_W-1:0]       win_fill;
   logic                    win_full;
   logic                    div_start;
   logic                    div_busy;
   logic [NUM_W-1:0]        div_quo;
   logic [TOTAL_W-1:0]      div_rem;
   logic                    round_up;
   logic                    quo_sat;
   logic                    quo_big;
   logic [OUT_W-1:0]        trunc_val;
   logic [OUT_W-1:0]        round_val;
   logic [PER_CW-1:0]       period_wide;
   logic [FILL_CW-1:0]      fill_wide;
   logic                    out_load;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign cnt_inc   = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
         rise_ff <= RISE_RESET;
         fall_ff <= FALL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLE_RATE: rate_ff <= csr_wdata;
            CSR_RISE_THRESH: rise_ff <= signed'(csr_wdata[MV_W-1:0]);
            CSR_FALL_THRESH: fall_ff <= signed'(csr_wdata[MV_W-1:0]);
            default: ;
         endcase
      end
   end

   // result rounding and saturation
   always_comb begin
      round_up  = ({div_rem, 1'b0} >= {1'b0, den_ff});
      quo_sat   = (div_quo >= NUM_W'(OUT_MAX));
      quo_big   = (div_quo > NUM_W'(OUT_MAX));
      trunc_val = quo_big ? OUT_MAX : div_quo[OUT_W-1:0];
      round_val = quo_sat ? OUT_MAX : div_quo[OUT_W-1:0] + OUT_W'(round_up);
      period_wide = PER_CW'(period_ff);
      fill_wide   = FILL_CW'(n_ff);
   end

   // edge detection and sequencer
   always_comb begin
      state_in     = state_ff;
      trig_in      = trig_ff;
      was_in       = was_ff;
      await_in     = await_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      period_in    = period_ff;
      edge_det     = 1'b0;
      await_eff    = await_ff;
      win_ctrl     = '0;
      div_start    = 1'b0;
      out_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (!req_connected) begin
                  was_in = 1'b0;
               end else begin
                  was_in    = 1'b1;
                  await_eff = was_ff ? await_ff : 1'b1;
                  await_in  = await_eff;
                  if (trig_ff) begin
                     if (req_sample_mv <= fall_ff) begin
                        trig_in = 1'b0;
                     end
                  end else if (req_sample_mv >= rise_ff) begin
                     trig_in  = 1'b1;
                     edge_det = 1'b1;
                  end
                  priority if (!edge_det) begin
                     cnt_in = cnt_inc;
                  end else if (await_eff) begin
                     // first edge of a connection only starts the count and clears the window
                     cnt_in         = '0;
                     await_in       = 1'b0;
                     win_ctrl.clear = 1'b1;
                  end else begin
                     cnt_in        = '0;
                     period_in     = cnt_inc;
                     win_ctrl.push = 1'b1;
                     state_in      = ST_MUL;
                  end
               end
            end
         end
         ST_MUL: begin
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            // drop the oldest entry once the window is full
            win_ctrl.sub = win_full;
            state_in     = ST_DSTART;
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load       = 1'b1;
               rsp_valid_in   = 1'b1;
               last_in        = trunc_val;
               win_ctrl.clear = (trunc_val != last_ff);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         trig_ff      <= 1'b0;
         was_ff       <= 1'b0;
         await_ff     <= 1'b1;
         cnt_ff       <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         trig_ff      <= trig_in;
         was_ff       <= was_in;
         await_ff     <= await_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // numerator products, one multiply per cycle
   always_ff @(posedge clock) begin
      period_ff <= period_in;
      if (state_ff == ST_MUL) begin
         r600_ff <= R600_W'(rate_ff) * R600_W'(TEMPO_SCALE);
         n_ff    <= win_fill;
         den_ff  <= win_total;
      end
      if (state_ff == ST_MUL2) begin
         num_ff <= NUM_W'(r600_ff) * NUM_W'(n_ff);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         tempo_out_ff  <= round_val;
         period_out_ff <= (period_wide > PER_CW'(OUT_MAX)) ? OUT_MAX
                                                           : period_wide[OUT_W-1:0];
         fill_out_ff   <= (fill_wide > FILL_CW'(FILL_OUT_MAX)) ? FILL_OUT_MAX
                                                               : fill_wide[FILL_OUT_W-1:0];
      end
   end

   ctm_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .COUNT_BITS   (COUNT_BITS),
      .TOTAL_W      (TOTAL_W),
      .FILL_W       (FILL_W)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (win_ctrl),
      .period (period_in),
      .total  (win_total),
      .fill   (win_fill),
      .full   (win_full)
   );

   ctm_divider #(
      .NUM_W (NUM_W),
      .DEN_W (TOTAL_W)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .busy  (div_busy),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tempo_tenths   = tempo_out_ff;
   assign rsp_period_samples = period_out_ff;
   assign rsp_window_fill    = fill_out_ff;

   // checks on sequencing and window bookkeeping
   `CTM_ASSERT_IMPL(a_rsp_from_fin, clock, reset, $rose(rsp_valid), $past(state_ff == ST_FIN))
   `CTM_ASSERT_IMPL(a_div_in_div_state, clock, reset, div_busy, state_ff == ST_DIV)
   `CTM_ASSERT_ALWAYS(a_fill_bound, clock, reset, win_fill <= FILL_W'(WINDOW_DEPTH))
   `CTM_ASSERT_IMPL(a_nonzero_den, clock, reset, state_ff == ST_DSTART, den_ff != '0)

endmodule

### src/ctm_divider.sv
`timescale 1ns / 1ps

module ctm_divider import ctm_pkg::*; #(
   parameter int NUM_W = 36,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   // one restoring step per cycle, quotient bits shift in from the right
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         if (!diff[DEN_W]) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

### src/ctm_window.sv
`timescale 1ns / 1ps

module ctm_window import ctm_pkg::*; #(
   parameter int WINDOW_DEPTH = 128,
   parameter int COUNT_BITS   = 24,
   parameter int TOTAL_W      = COUNT_BITS + $clog2(WINDOW_DEPTH) + 1,
   parameter int FILL_W       = $clog2(WINDOW_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  window_ctrl_type       ctrl,
   input  logic [COUNT_BITS-1:0] period,
   output logic [TOTAL_W-1:0]    total,
   output logic [FILL_W-1:0]     fill,
   output logic                  full
);

   localparam int PTR_W = $clog2(WINDOW_DEPTH);

   logic [COUNT_BITS-1:0] mem [WINDOW_DEPTH];
   logic [COUNT_BITS-1:0] rd_ff;
   logic [PTR_W-1:0]      wp_ff, wp_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic                  full_now;

   assign full_now = (fill_ff == FILL_W'(WINDOW_DEPTH));

   // pointer, fill and running total
   always_comb begin
      wp_in    = wp_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      priority if (ctrl.clear) begin
         wp_in    = '0;
         fill_in  = '0;
         total_in = '0;
      end else if (ctrl.push) begin
         wp_in    = (wp_ff == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         fill_in  = full_now ? fill_ff : fill_ff + 1'b1;
         total_in = total_ff + TOTAL_W'(period);
      end else if (ctrl.sub) begin
         total_in = total_ff - TOTAL_W'(rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         fill_ff  <= '0;
         total_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
      end
   end

   // period storage, read port follows the write pointer (oldest entry)
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[wp_ff] <= period;
      end
      rd_ff <= mem[wp_ff];
   end

   assign total = total_ff;
   assign fill  = fill_ff;
   assign full  = full_now;

endmodule
